FILE: rtl/core/nta_pkg.sv
package nta_pkg;

	localparam int ADDR_W = 48;
	localparam int HDR_W  = 32;
	localparam int SLOT_W = 5;
	localparam int MASK_W = 16;

	// request codes
	localparam logic REQ_ADV  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// priority chain passed from cell to cell, lower slots first
	typedef struct packed {
		logic hit;   // some earlier cell holds the address
		logic free;  // some earlier cell has zero age
	} chain_t;

	// command broadcast to every cell
	typedef struct packed {
		logic adv;     // advertisement beat with a matching header
		logic tick;    // aging tick beat
		logic any_hit; // address found somewhere in the table
	} cmd_t;

endpackage

FILE: rtl/core/nta_if.sv
interface nta_req_if;
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [nta_pkg::ADDR_W-1:0] node_address;
	logic [nta_pkg::HDR_W-1:0]  header_word;

	modport source (output valid, req_type, node_address, header_word, input ready);
	modport sink   (input valid, req_type, node_address, header_word, output ready);
endinterface

interface nta_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [nta_pkg::SLOT_W-1:0] slot_index;
	logic                       stored;
	logic [nta_pkg::MASK_W-1:0] live_mask;

	modport source (output valid, slot_index, stored, live_mask, input ready);
	modport sink   (input valid, slot_index, stored, live_mask, output ready);
endinterface

interface nta_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [nta_pkg::HDR_W-1:0] frame_header;

	modport source (output valid, frame_header, input ready);
	modport sink   (input valid, frame_header, output ready);
endinterface

FILE: rtl/core/nta_cell.sv
module nta_cell #(
	parameter int AGE_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nta_pkg::cmd_t              cmd,
	input  logic [nta_pkg::ADDR_W-1:0] addr,
	input  nta_pkg::chain_t            chain_in,
	output nta_pkg::chain_t            chain_out,
	output logic                       win,
	output logic                       alive_next
);

	logic [nta_pkg::ADDR_W-1:0] addr_q;
	logic [AGE_BITS-1:0]        age_q;
	logic [AGE_BITS-1:0]        age_next;
	logic                       alive_q;
	logic                       match;
	logic                       free;

	// local compare against the stored entry
	assign match = (addr_q == addr);
	assign free  = (age_q == '0);

	// extend the priority chain toward higher slots
	assign chain_out.hit  = chain_in.hit | match;
	assign chain_out.free = chain_in.free | free;

	// first matching cell wins, else first free cell claims
	assign win = cmd.adv & (cmd.any_hit ? (match & ~chain_in.hit)
	                                    : (free & ~chain_in.free));

	// next age and live bit
	always_comb begin
		age_next   = age_q;
		alive_next = alive_q;
		if (win) begin
			age_next   = AGE_BITS'(1);
			alive_next = 1'b1;
		end else if (cmd.tick) begin
			if (free) begin
				alive_next = 1'b0;
			end else begin
				age_next = age_q << 1;
			end
		end
	end

	// entry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			age_q   <= '0;
			alive_q <= 1'b0;
		end else begin
			if (win) begin
				addr_q <= addr;
			end
			age_q   <= age_next;
			alive_q <= alive_next;
		end
	end

endmodule

FILE: rtl/core/node_table_with_aging.sv
// channel  dir  contents
// cfg      in   frame_header
// req      in   req_type, node_address, header_word
// rsp      out  slot_index, stored, live_mask
//
// one beat per cycle when rsp drains: a request updates the table and
// loads the rsp register on acceptance; the cell chain sets that path
// req is ready whenever the response register is empty or being drained
// cfg is always ready
// reset clears the table, ages, live mask and header register
module node_table_with_aging #(
	parameter int NODES    = 16,
	parameter int AGE_BITS = 8
) (
	input logic    clk,
	input logic    arst_n,
	nta_cfg_if.sink cfg,
	nta_req_if.sink req,
	nta_rsp_if.source rsp
);

	logic [nta_pkg::HDR_W-1:0]  hdr_q;
	logic                       req_acc;
	nta_pkg::cmd_t              cmd;
	nta_pkg::chain_t            chain [NODES+1];
	logic [NODES-1:0]           win_vec;
	logic [NODES-1:0]           alive_vec;
	logic [nta_pkg::MASK_W+NODES-1:0] mask_ext;
	logic [nta_pkg::SLOT_W-1:0] slot_d;
	logic                       rsp_valid_q;
	logic [nta_pkg::SLOT_W-1:0] slot_q;
	logic                       stored_q;
	logic [nta_pkg::MASK_W-1:0] mask_q;

	// header register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
		end else if (cfg.valid) begin
			hdr_q <= cfg.frame_header;
		end
	end

	// request handshake and broadcast command
	assign req.ready   = ~rsp_valid_q | rsp.ready;
	assign req_acc     = req.valid & req.ready;
	assign cmd.adv     = req_acc & (req.req_type == nta_pkg::REQ_ADV)
	                   & (req.header_word == hdr_q);
	assign cmd.tick    = req_acc & (req.req_type == nta_pkg::REQ_TICK);
	assign cmd.any_hit = chain[NODES].hit;
	assign chain[0]    = '0;

	// row of table cells
	for (genvar i = 0; i < NODES; i++) begin : g_cell
		nta_cell #(
			.AGE_BITS (AGE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.addr       (req.node_address),
			.chain_in   (chain[i]),
			.chain_out  (chain[i+1]),
			.win        (win_vec[i]),
			.alive_next (alive_vec[i])
		);
	end

	// slot index of the winning cell, NODES when none
	always_comb begin
		slot_d = '0;
		for (int i = 0; i < NODES; i++) begin
			if (win_vec[i]) begin
				slot_d = slot_d | nta_pkg::SLOT_W'(i);
			end
		end
		if (win_vec == '0) begin
			slot_d = nta_pkg::SLOT_W'(NODES);
		end
	end

	assign mask_ext = {{nta_pkg::MASK_W{1'b0}}, alive_vec};

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_acc) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			slot_q   <= slot_d;
			stored_q <= |win_vec;
			mask_q   <= mask_ext[nta_pkg::MASK_W-1:0];
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.slot_index = slot_q;
	assign rsp.stored     = stored_q;
	assign rsp.live_mask  = mask_q;

`ifndef NO_ASSERTIONS
	// at most one cell takes an advertisement
	a_one_winner: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(win_vec))
		else $error("more than one cell claimed the beat");

	// a cell only wins on an accepted advertisement with a good header
	a_win_needs_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(win_vec != '0) |-> cmd.adv)
		else $error("cell won without an advertisement");

	// ticks and wrong headers never report a stored slot
	a_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && !cmd.adv) |=> (rsp.valid && !rsp.stored))
		else $error("stored flag set on tick or bad header");

	// an advertisement whose address is found always wins a slot
	a_hit_wins: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.adv && cmd.any_hit) |-> (win_vec != '0))
		else $error("matching address did not win a slot");
`endif

endmodule

FILE: test/node_table_with_aging_tb.sv
`timescale 1ns / 1ps

module node_table_with_aging_tb;

	localparam int NODES      = 16;
	localparam int AGE_BITS   = 8;
	localparam int PHASES     = 7;
	localparam int PHASE_LEN  = 130;
	localparam int SETTLE     = 3;
	localparam int IDLE_LIMIT = 4000;

	typedef struct packed {
		logic                       kind;
		logic [nta_pkg::ADDR_W-1:0] addr;
		logic [nta_pkg::HDR_W-1:0]  hdr;
	} adv_beat_t;

	typedef struct packed {
		logic [nta_pkg::SLOT_W-1:0] slot;
		logic                       stored;
		logic [nta_pkg::MASK_W-1:0] live;
	} slot_rsp_t;

	logic clk;
	logic arst_n;

	nta_cfg_if cfg_ch ();
	nta_req_if req_ch ();
	nta_rsp_if rsp_ch ();

	node_table_with_aging #(
		.NODES(NODES),
		.AGE_BITS(AGE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// shadow copy of the table
	logic [nta_pkg::ADDR_W-1:0] shadow_addr [NODES];
	logic [AGE_BITS-1:0]        node_age [NODES];
	logic [NODES-1:0]           alive_mask;
	logic [nta_pkg::HDR_W-1:0]  header_reg;

	adv_beat_t pending_beats [$];
	slot_rsp_t expected_rsps [$];

	int errors;
	int n_stored, n_full, n_bad_hdr, n_ticks, n_rsps;

	logic req_fire;
	int   burst_left, gap_left;
	int   stall_mode, stall_cnt;

	logic [nta_pkg::ADDR_W-1:0] addr_pool [32];

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [nta_pkg::ADDR_W-1:0] rand_addr();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// advance the shadow table by one accepted beat and give its response
	function automatic slot_rsp_t apply_beat(adv_beat_t b);
		slot_rsp_t r;
		bit        found;
		r.slot   = nta_pkg::SLOT_W'(NODES);
		r.stored = 1'b0;
		found    = 1'b0;
		if (b.kind == nta_pkg::REQ_TICK) begin
			n_ticks++;
			for (int i = 0; i < NODES; i++) begin
				if (node_age[i] != '0)
					node_age[i] = node_age[i] << 1;
				else
					alive_mask[i] = 1'b0;
			end
		end else if (b.hdr != header_reg) begin
			n_bad_hdr++;
		end else begin
			// address hit first, dead and never-written slots included
			for (int i = 0; i < NODES; i++) begin
				if (!found && shadow_addr[i] == b.addr) begin
					found  = 1'b1;
					r.slot = nta_pkg::SLOT_W'(i);
				end
			end
			// otherwise claim the lowest slot with zero age
			for (int i = 0; i < NODES; i++) begin
				if (!found && node_age[i] == '0) begin
					found          = 1'b1;
					r.slot         = nta_pkg::SLOT_W'(i);
					shadow_addr[i] = b.addr;
				end
			end
			if (found) begin
				node_age[r.slot]   = AGE_BITS'(1);
				alive_mask[r.slot] = 1'b1;
				r.stored           = 1'b1;
				n_stored++;
			end else begin
				n_full++;
			end
		end
		r.live = nta_pkg::MASK_W'(alive_mask);
		return r;
	endfunction

	// scoreboard: check response beats, predict on request and config beats
	always @(posedge clk) begin
		if (!arst_n) begin
			req_fire <= 1'b0;
		end else begin
			req_fire <= req_ch.valid && req_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				slot_rsp_t want;
				n_rsps++;
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response slot %0d stored %0b live %h",
						$time, rsp_ch.slot_index, rsp_ch.stored, rsp_ch.live_mask);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_ch.slot_index !== want.slot) begin
						$display("%0t: slot_index expected %0d actual %0d",
							$time, want.slot, rsp_ch.slot_index);
						errors++;
					end
					if (rsp_ch.stored !== want.stored) begin
						$display("%0t: stored expected %0b actual %0b",
							$time, want.stored, rsp_ch.stored);
						errors++;
					end
					if (rsp_ch.live_mask !== want.live) begin
						$display("%0t: live_mask expected %h actual %h",
							$time, want.live, rsp_ch.live_mask);
						errors++;
					end
				end
			end
			if (cfg_ch.valid && cfg_ch.ready)
				header_reg = cfg_ch.frame_header;
			if (req_ch.valid && req_ch.ready) begin
				adv_beat_t b;
				b.kind = req_ch.req_type;
				b.addr = req_ch.node_address;
				b.hdr  = req_ch.header_word;
				expected_rsps.push_back(apply_beat(b));
				void'(pending_beats.pop_front());
			end
		end
	end

	// request driver: bursts with random gaps, beat held until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_fire) begin
			if (gap_left != 0) begin
				gap_left     <= gap_left - 1;
				req_ch.valid <= 1'b0;
			end else if (pending_beats.size() != 0) begin
				req_ch.valid        <= 1'b1;
				req_ch.req_type     <= pending_beats[0].kind;
				req_ch.node_address <= pending_beats[0].addr;
				req_ch.header_word  <= pending_beats[0].hdr;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(40, 1);
					gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// response stall pattern: always ready, coin flip, or mostly stalled
	always @(negedge clk) begin
		if (stall_cnt == 0) begin
			stall_mode <= $urandom_range(2);
			stall_cnt  <= $urandom_range(100, 20);
		end else begin
			stall_cnt <= stall_cnt - 1;
		end
		case (stall_mode)
			0: begin
				rsp_ch.ready <= 1'b1;
			end
			1: begin
				rsp_ch.ready <= 1'($urandom_range(1));
			end
			default: begin
				rsp_ch.ready <= ($urandom_range(7) == 0);
			end
		endcase
	end

	// watchdog on cycles with no beat on any channel
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic push_adv(logic [nta_pkg::ADDR_W-1:0] addr, logic [nta_pkg::HDR_W-1:0] hdr);
		adv_beat_t b;
		b.kind = nta_pkg::REQ_ADV;
		b.addr = addr;
		b.hdr  = hdr;
		pending_beats.push_back(b);
	endtask

	// tick beats carry junk in the ignored fields
	task automatic push_tick();
		adv_beat_t b;
		b.kind = nta_pkg::REQ_TICK;
		b.addr = rand_addr();
		b.hdr  = $urandom;
		pending_beats.push_back(b);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_beats.size() != 0 || expected_rsps.size() != 0 || req_ch.valid);
	endtask

	task automatic write_header(logic [nta_pkg::HDR_W-1:0] value);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid        = 1'b1;
		cfg_ch.frame_header = value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	initial begin : stimulus
		logic [nta_pkg::HDR_W-1:0]  cur_hdr;
		int                         tick_pct, pool_sz, pick;
		logic [nta_pkg::ADDR_W-1:0] addr;
		logic [nta_pkg::HDR_W-1:0]  hdr;

		errors     = 0;
		n_stored   = 0;
		n_full     = 0;
		n_bad_hdr  = 0;
		n_ticks    = 0;
		n_rsps     = 0;
		burst_left = 1;
		gap_left   = 0;
		stall_mode = 0;
		stall_cnt  = 0;
		alive_mask = '0;
		header_reg = '0;
		for (int i = 0; i < NODES; i++) begin
			shadow_addr[i] = '0;
			node_age[i]    = '0;
		end
		arst_n              = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.frame_header = '0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = nta_pkg::REQ_ADV;
		req_ch.node_address = '0;
		req_ch.header_word  = '0;
		rsp_ch.ready        = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, header still at its reset value of zero
		// address zero hits the never-written slot 0
		push_adv('0, '0);
		push_adv('1, '0);
		// header mismatch, off by one bit and all ones
		push_adv('1, 32'h1);
		push_adv(48'h1234_5678_9ABC, '1);
		// fill the rest of the table, then one more address finds it full
		for (int i = 0; i < 14; i++)
			push_adv(48'h100 + i, '0);
		push_adv(48'hDEAD_BEEF_0000, '0);
		// refresh of an existing entry
		push_adv('1, '0);
		// ages walk off the top after eight ticks, live bits drop on the ninth
		repeat (9) push_tick();
		push_adv(48'h0000_BEEF_0001, '0);
		wait_drained();

		// random phases, each with its own header and traffic mix
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					cur_hdr = '1;
					tick_pct = 5;
					pool_sz = 20;
				end
				1: begin
					cur_hdr = '0;
					tick_pct = 10;
					pool_sz = 12;
				end
				3: begin
					cur_hdr = 32'h8000_0001;
					tick_pct = 50;
					pool_sz = 18;
				end
				5: begin
					cur_hdr = $urandom;
					tick_pct = 3;
					pool_sz = 30;
				end
				default: begin
					cur_hdr = $urandom;
					tick_pct = $urandom_range(25, 8);
					pool_sz = $urandom_range(28, 14);
				end
			endcase
			write_header(cur_hdr);
			for (int i = 0; i < 32; i++) begin
				pick = $urandom_range(15);
				addr_pool[i] = (pick == 0) ? '0 : (pick == 1) ? '1 : rand_addr();
			end
			for (int n = 0; n < PHASE_LEN; n++) begin
				if ($urandom_range(99) < tick_pct) begin
					push_tick();
				end else begin
					addr = ($urandom_range(9) == 0) ? rand_addr() :
						addr_pool[$urandom_range(pool_sz - 1)];
					pick = $urandom_range(99);
					if (pick < 88)
						hdr = cur_hdr;
					else if (pick < 94)
						hdr = $urandom;
					else
						hdr = cur_hdr ^ (32'h1 << $urandom_range(nta_pkg::HDR_W - 1));
					push_adv(addr, hdr);
				end
			end
			wait_drained();
		end

		repeat (5) @(posedge clk);
		$display("run covered %0d responses over %0d header settings", n_rsps, PHASES + 1);
		$display("stored %0d, table full %0d, header rejects %0d, aging ticks %0d",
			n_stored, n_full, n_bad_hdr, n_ticks);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/nta_pkg.sv
rtl/core/nta_if.sv
rtl/core/nta_cell.sv
rtl/core/node_table_with_aging.sv
test/node_table_with_aging_tb.sv
